// ----- hw/rtl/dcad_pkg.sv -----
package dcad_pkg;

	// field widths
	localparam int WH_W      = 24;
	localparam int PCT_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERCENT = 2'd1;

	// register reset values
	localparam logic             ENABLE_RESET  = 1'b1;
	localparam logic [PCT_W-1:0] PERCENT_RESET = 10'd30;

	// detection constants
	localparam int               MIN_DAYS        = 3;
	localparam logic [PCT_W-1:0] DEFAULT_PERCENT = 10'd30;
	localparam int               PERCENT_BASE    = 100;

	// serial divider: one quotient bit per cycle
	localparam int               DCNT_W    = 5;
	localparam logic [DCNT_W-1:0] DIV_STEPS = 5'd24;

	// product width for the limit compare
	localparam int PROD_W = WH_W + PCT_W;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic check;
		logic ptr_step;
		logic sum_add;
		logic div_init;
		logic div_step;
		logic mul;
		logic load_out;
		logic out_zero;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic enable;
		logic few_days;
		logic sum_last;
		logic sum_zero;
		logic div_last;
	} sts_t;

endpackage

// ----- hw/rtl/dcad_ctrl.sv -----
module dcad_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  dcad_pkg::sts_t  sts,
	output dcad_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_CHECK    = 3'd1;
	localparam logic [2:0] ST_PREFETCH = 3'd2;
	localparam logic [2:0] ST_SUM      = 3'd3;
	localparam logic [2:0] ST_DIVINIT  = 3'd4;
	localparam logic [2:0] ST_DIV      = 3'd5;
	localparam logic [2:0] ST_MUL      = 3'd6;
	localparam logic [2:0] ST_DONE     = 3'd7;

	logic [2:0] state_q, state_d;
	logic       zero_q, zero_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		zero_d       = zero_q;
		cmd          = '0;
		cmd.out_zero = zero_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					if (sts.enable) begin
						state_d = ST_CHECK;
					end else begin
						zero_d  = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (sts.few_days) begin
					zero_d  = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_PREFETCH;
				end
			end
			ST_PREFETCH: begin
				cmd.ptr_step = 1'b1;
				state_d      = ST_SUM;
			end
			ST_SUM: begin
				cmd.ptr_step = 1'b1;
				cmd.sum_add  = 1'b1;
				if (sts.sum_last) begin
					state_d = ST_DIVINIT;
				end
			end
			ST_DIVINIT: begin
				if (sts.sum_zero) begin
					zero_d  = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				zero_d  = 1'b0;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					zero_d       = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			zero_q  <= zero_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/dcad_datapath.sv -----
module dcad_datapath #(
	parameter int DAYS = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [dcad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dcad_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic [dcad_pkg::WH_W-1:0]         today_wh,
	input  dcad_pkg::cmd_t                    cmd,
	output dcad_pkg::sts_t                    sts,
	output logic                              alert,
	output logic                              compared,
	output logic [dcad_pkg::WH_W-1:0]         average_wh
);

	localparam int CW = $clog2(DAYS);
	localparam int FW = $clog2(DAYS + 1);
	localparam int SW = dcad_pkg::WH_W + CW;
	localparam int WH_W   = dcad_pkg::WH_W;
	localparam int PCT_W  = dcad_pkg::PCT_W;
	localparam int PROD_W = dcad_pkg::PROD_W;

	// configuration
	logic             enable_q;
	logic [PCT_W-1:0] pct_q;
	logic [PCT_W-1:0] pct_eff;

	// history ring
	logic [WH_W-1:0] mem [DAYS];
	logic [WH_W-1:0] rdata_q;
	logic [CW-1:0]   wp_q;
	logic [FW-1:0]   filled_q;
	logic [CW-1:0]   today_pos_q;
	logic [CW-1:0]   ptr_q;
	logic [WH_W-1:0] today_q;

	// summation
	logic [SW-1:0]   sum_q;
	logic [CW-1:0]   sum_cnt_q;
	logic [CW-1:0]   count_q;

	// serial divider
	logic [CW-1:0]                 div_rem_q;
	logic [WH_W-1:0]               div_quo_q;
	logic [dcad_pkg::DCNT_W-1:0]   div_cnt_q;
	logic [CW:0]                   trial;
	logic [CW:0]                   trial_sub;
	logic                          trial_ge;

	// limit compare
	logic [PROD_W-1:0] prod_pct_q;
	logic [PROD_W-1:0] prod_diff_q;
	logic              above_q;
	logic [WH_W-1:0]   diff;
	logic              alert_c;

	// output beat
	logic            alert_q;
	logic            compared_q;
	logic [WH_W-1:0] average_q;

	assign pct_eff = (pct_q == '0) ? dcad_pkg::DEFAULT_PERCENT : pct_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= dcad_pkg::ENABLE_RESET;
			pct_q    <= dcad_pkg::PERCENT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == dcad_pkg::REG_ENABLE) begin
				enable_q <= cfg_data[0];
			end else if (cfg_index == dcad_pkg::REG_PERCENT) begin
				pct_q <= cfg_data[PCT_W-1:0];
			end
		end
	end

	// ring control: write position, fill count, read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			filled_q <= '0;
			ptr_q    <= '0;
		end else begin
			if (cmd.accept && enable_q) begin
				wp_q <= (wp_q == CW'(DAYS - 1)) ? '0 : wp_q + CW'(1);
				if (filled_q != FW'(DAYS)) begin
					filled_q <= filled_q + FW'(1);
				end
			end
			if (cmd.check) begin
				ptr_q <= (today_pos_q == '0) ? CW'(DAYS - 1) : today_pos_q - CW'(1);
			end else if (cmd.ptr_step) begin
				ptr_q <= (ptr_q == '0) ? CW'(DAYS - 1) : ptr_q - CW'(1);
			end
		end
	end

	// history memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.accept && enable_q) begin
			mem[wp_q] <= today_wh;
		end
		rdata_q <= mem[ptr_q];
	end

	// capture of the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			today_q     <= today_wh;
			today_pos_q <= wp_q;
		end
	end

	// sum of the earlier days, newest first
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			sum_q     <= '0;
			sum_cnt_q <= CW'(filled_q - FW'(1));
			count_q   <= CW'(filled_q - FW'(1));
		end else if (cmd.sum_add) begin
			sum_q     <= sum_q + SW'(rdata_q);
			sum_cnt_q <= sum_cnt_q - CW'(1);
		end
	end

	// restoring division; the upper sum bits are already below the count
	assign trial     = {div_rem_q, div_quo_q[WH_W-1]};
	assign trial_ge  = trial >= {1'b0, count_q};
	assign trial_sub = trial - {1'b0, count_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			div_rem_q <= sum_q[SW-1:WH_W];
			div_quo_q <= sum_q[WH_W-1:0];
			div_cnt_q <= dcad_pkg::DIV_STEPS;
		end else if (cmd.div_step) begin
			div_rem_q <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
			div_quo_q <= {div_quo_q[WH_W-2:0], trial_ge};
			div_cnt_q <= div_cnt_q - dcad_pkg::DCNT_W'(1);
		end
	end

	// today > avg + floor(avg*pct/100)  <=>  (today-avg)*100 > avg*pct
	assign diff = today_q - div_quo_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			above_q     <= today_q > div_quo_q;
			prod_pct_q  <= PROD_W'(div_quo_q) * PROD_W'(pct_eff);
			prod_diff_q <= PROD_W'(diff) * PROD_W'(dcad_pkg::PERCENT_BASE);
		end
	end

	assign alert_c = above_q && (prod_diff_q > prod_pct_q);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			alert_q    <= cmd.out_zero ? 1'b0 : alert_c;
			compared_q <= !cmd.out_zero;
			average_q  <= cmd.out_zero ? '0 : div_quo_q;
		end
	end

	assign alert      = alert_q;
	assign compared   = compared_q;
	assign average_wh = average_q;

	// status
	assign sts.enable   = enable_q;
	assign sts.few_days = filled_q < FW'(dcad_pkg::MIN_DAYS);
	assign sts.sum_last = (sum_cnt_q == CW'(1));
	assign sts.sum_zero = (sum_q == '0);
	assign sts.div_last = (div_cnt_q == dcad_pkg::DCNT_W'(1));

endmodule

// ----- hw/rtl/daily_consumption_anomaly_detector.sv -----
// sequencing: a disabled block sends the accepted item straight to a zero result; with fewer than three days
// held, the day check ends it with a zero result; a full check sums the earlier days, one stored day per cycle,
// then runs the divider, one quotient bit per cycle, and the limit compare; one item is in work at a time
// the next item is taken while the result waits in the output register
// reset: arst_n clears write position, fill count and controller; enable returns to 1 and
// excess_percent to 30; history contents stay undefined until written
module daily_consumption_anomaly_detector #(
	parameter int DAYS = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dcad_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcad_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dcad_pkg::WH_W-1:0]      today_wh,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           alert,
	output logic                           compared,
	output logic [dcad_pkg::WH_W-1:0]      average_wh
);

	dcad_pkg::cmd_t cmd;
	dcad_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer
	dcad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// history, sum, divider and limit compare
	dcad_datapath #(
		.DAYS (DAYS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.today_wh   (today_wh),
		.cmd        (cmd),
		.sts        (sts),
		.alert      (alert),
		.compared   (compared),
		.average_wh (average_wh)
	);

`ifndef SYNTHESIS
	// a result without comparison carries no alert and no average
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !compared) |-> (!alert && average_wh == '0))
		else $error("uncompared result carries data");

	// one item at a time: the beat after an accept is stalled
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in work");

	// a new result only comes out of a busy sequencer
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");
`endif

endmodule

// ----- tb/sv/tb_daily_consumption_anomaly_detector.sv -----
module tb_daily_consumption_anomaly_detector;
	import dcad_pkg::*;

	localparam int DAYS         = 7;
	localparam int ITEM_TARGET  = 650;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 150;
	localparam int CYCLE_LIMIT  = 1000000;

	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	typedef struct packed {
		logic            alert;
		logic            compared;
		logic [WH_W-1:0] avg;
	} day_verdict_t;

	localparam day_verdict_t NO_VERDICT = '0;

	typedef enum logic [1:0] {ROW_DAY, ROW_DAY_WANT, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] data;
		logic [WH_W-1:0]      wh;
		day_verdict_t         want;
	} day_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [WH_W-1:0]      today_wh = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 alert;
	logic                 compared;
	logic [WH_W-1:0]      average_wh;

	// detector state as the testbench tracks it
	logic [WH_W-1:0]  history [0:DAYS-1];
	int               wr_pos = 0;
	int               fill_cnt = 0;
	logic             en_q = ENABLE_RESET;
	logic [PCT_W-1:0] pct_q = PERCENT_RESET;

	day_verdict_t pending_days [$];
	int           mismatches = 0;
	int           days_offered = 0;
	int           cycle_cnt = 0;
	logic         calm = 1'b0;

	// directed rows: fixed expectations only where they are obvious
	day_row_t plan [0:26] = '{
		'{ROW_DAY_WANT, REG_ENABLE,   10'd0,     24'd0,        NO_VERDICT},
		'{ROW_DAY_WANT, REG_ENABLE,   10'd0,     24'd0,        NO_VERDICT},
		'{ROW_DAY_WANT, REG_ENABLE,   10'd0,     24'd0,        NO_VERDICT},
		'{ROW_DAY_WANT, REG_ENABLE,   10'd0,     24'hFFFFFF,   NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd0,        NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'hFFFFFF,   NO_VERDICT},
		'{ROW_REG,      REG_PERCENT,  10'd0,     24'd0,        NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd100,      NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd100,      NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd100,      NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd100,      NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd100,      NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd100,      NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd100,      NO_VERDICT},
		'{ROW_DAY_WANT, REG_ENABLE,   10'd0,     24'd130,      '{1'b0, 1'b1, 24'd100}},
		'{ROW_REG,      REG_PERCENT,  10'd1023,  24'd0,        NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'hFFFFFF,   NO_VERDICT},
		'{ROW_REG,      REG_PERCENT,  10'd1,     24'd0,        NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd0,        NO_VERDICT},
		'{ROW_REG,      REG_ENABLE,   10'h3FE,   24'd0,        NO_VERDICT},
		'{ROW_DAY_WANT, REG_ENABLE,   10'd0,     24'd5,        NO_VERDICT},
		'{ROW_DAY_WANT, REG_ENABLE,   10'd0,     24'hFFFFFF,   NO_VERDICT},
		'{ROW_REG,      REG_ENABLE,   10'h001,   24'd0,        NO_VERDICT},
		'{ROW_REG,      REG_UNUSED_2, 10'd0,     24'd0,        NO_VERDICT},
		'{ROW_REG,      REG_UNUSED_3, 10'd0,     24'd0,        NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'd1,        NO_VERDICT},
		'{ROW_DAY,      REG_ENABLE,   10'd0,     24'hFFFFFF,   NO_VERDICT}
	};

	daily_consumption_anomaly_detector #(.DAYS(DAYS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.today_wh   (today_wh),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.alert      (alert),
		.compared   (compared),
		.average_wh (average_wh)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// store today, then judge it against the mean of the earlier days
	function day_verdict_t predict_day(input logic [WH_W-1:0] wh);
		day_verdict_t v;
		logic [63:0]  sum;
		logic [63:0]  avg;
		logic [63:0]  pct;
		logic [63:0]  lim;
		int           k;
		v = NO_VERDICT;
		if (!en_q)
			return v;
		history[wr_pos] = wh;
		wr_pos = (wr_pos + 1) % DAYS;
		if (fill_cnt < DAYS)
			fill_cnt++;
		if (fill_cnt < MIN_DAYS)
			return v;
		sum = 0;
		for (k = 1; k < fill_cnt; k++)
			sum += 64'(history[(wr_pos + 2 * DAYS - 1 - k) % DAYS]);
		if (sum == 0)
			return v;
		avg = sum / 64'(fill_cnt - 1);
		pct = (pct_q == 0) ? 64'(DEFAULT_PERCENT) : 64'(pct_q);
		lim = avg + (avg * pct) / 64'(PERCENT_BASE);
		v.alert    = (64'(wh) > lim);
		v.compared = 1'b1;
		v.avg      = avg[WH_W-1:0];
		return v;
	endfunction

	task report(input string field, input logic [WH_W-1:0] got, input logic [WH_W-1:0] want);
		$display("mismatch on %s: got %0d expected %0d at cycle %0d", field, got, want, cycle_cnt);
		mismatches++;
	endtask

	// drop valid and let the block run dry
	task wait_idle();
		in_valid <= 1'b0;
		while (pending_days.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, only ever from idle
	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ENABLE:  en_q = data[0];
			REG_PERCENT: pct_q = data[PCT_W-1:0];
			default: ;
		endcase
	endtask

	// offer one day total; returns at the edge of its beat with valid still up
	task send_day(input logic [WH_W-1:0] wh, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		today_wh <= wh;
		do
			@(posedge clk);
		while (in_stall);
		days_offered++;
	endtask

	// output stalls, plus one long hold that backs the block up
	initial begin
		int   run_left;
		int   stall_left;
		int   hold_left;
		logic held;
		run_left   = 0;
		stall_left = 0;
		hold_left  = 0;
		held       = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && days_offered >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (run_left > 0) begin
					run_left--;
				end else begin
					run_left   = $urandom_range(0, 12);
					stall_left = calm ? 0 : pick_gap();
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		day_verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_days.size() == 0) begin
				report("unexpected result beat", average_wh, '0);
			end else begin
				want = pending_days.pop_front();
				if (alert !== want.alert)
					report("alert", WH_W'(alert), WH_W'(want.alert));
				if (compared !== want.compared)
					report("compared", WH_W'(compared), WH_W'(want.compared));
				if (average_wh !== want.avg)
					report("average_wh", average_wh, want.avg);
			end
		end
	end

	// stimulus
	initial begin
		day_verdict_t     v;
		logic [WH_W-1:0]  wh;
		logic [63:0]      base;
		logic [63:0]      wh64;
		logic [63:0]      eff;
		logic [CFG_DAT_W-1:0] d;
		logic             en;
		logic             flat;
		int               i;
		int               n;
		int               r;
		int               enabled_days;
		enabled_days = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (i = 0; i < $size(plan); i++) begin
			if (plan[i].kind == ROW_REG) begin
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_day(plan[i].wh, pick_gap());
				v = predict_day(plan[i].wh);
				pending_days.push_back(plan[i].kind == ROW_DAY_WANT ? plan[i].want : v);
			end
		end

		// random phases, each with its own settings
		while (enabled_days < ITEM_TARGET) begin
			r = $urandom_range(0, 7);
			case (r)
				0: d = 10'd0;
				1: d = 10'd1;
				2: d = 10'd1000;
				3: d = 10'd1023;
				4: d = DEFAULT_PERCENT;
				default: d = CFG_DAT_W'($urandom_range(1, 1000));
			endcase
			write_reg(REG_PERCENT, d);
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
					CFG_DAT_W'($urandom));
			en   = ($urandom_range(0, 6) != 0);
			d    = CFG_DAT_W'($urandom);
			d[0] = en;
			write_reg(REG_ENABLE, d);

			calm = ($urandom_range(0, 4) == 0);
			flat = ($urandom_range(0, 9) < 3);
			base = 64'($urandom_range(0, (32'd1 << $urandom_range(1, 24)) - 1));
			eff  = (pct_q == 0) ? 64'(DEFAULT_PERCENT) : 64'(pct_q);
			n    = en ? $urandom_range(20, 90) : $urandom_range(4, 12);

			repeat (n) begin
				r = $urandom_range(0, 99);
				if (flat) begin
					// steady days with a probe right at the limit
					if (r < 80) begin
						wh64 = base;
					end else begin
						wh64 = base + (base * eff) / PERCENT_BASE + $urandom_range(0, 2);
						if (wh64 != 0)
							wh64 = wh64 - 1;
					end
				end else if (r < 55) begin
					wh64 = base / 2 + $urandom_range(0, base[31:0]);
				end else if (r < 75) begin
					wh64 = base + (base * $urandom_range(0, 300)) / 100;
				end else if (r < 85) begin
					wh64 = 64'd0;
				end else if (r < 90) begin
					wh64 = 64'hFFFFFF;
				end else begin
					wh64 = 64'($urandom & 32'hFFFFFF);
				end
				wh = (wh64 > 64'hFFFFFF) ? 24'hFFFFFF : wh64[WH_W-1:0];
				send_day(wh, calm ? 0 : pick_gap());
				v = predict_day(wh);
				pending_days.push_back(v);
				if (en)
					enabled_days++;
			end
		end

		// drain and finish
		wait_idle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
